>>> rtl/trs_to_affine_matrix_macros.svh
// ----------------------------------------------------------------------------
// trs_to_affine_matrix assertion macros
// Concurrent checks used at the end of the top level; clk and arst_n are
// taken from the scope of the module that uses them.
// ----------------------------------------------------------------------------
`ifndef TRS_TO_AFFINE_MATRIX_MACROS_SVH
`define TRS_TO_AFFINE_MATRIX_MACROS_SVH

// Same-cycle implication.
`define TTA_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define TTA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/tta_pkg.sv
// ----------------------------------------------------------------------------
// tta_pkg
// Widths, fixed-point constants and the round/saturate function of the
// TRS to affine matrix pipeline.
// ----------------------------------------------------------------------------
package tta_pkg;

	localparam int TransW  = 32;
	localparam int QuatW   = 16;
	localparam int ScaleW  = 32;
	localparam int OutW    = 32;
	localparam int ProdW   = 2 * QuatW;            // quaternion products
	localparam int RotW    = ProdW + 2;            // rotation entries, Q.28
	localparam int FracRot = 28;
	localparam int LoW     = (RotW + 1) / 2;       // unsigned low slice of an entry
	localparam int HiW     = RotW - LoW;           // signed high slice
	localparam int PartLoW = LoW + 1 + ScaleW;
	localparam int PartHiW = HiW + ScaleW;
	localparam int FullW   = RotW + ScaleW;        // exact entry times scale
	localparam int RoundW  = FullW - FracRot;

	typedef logic signed [TransW-1:0]  trans_t;
	typedef logic signed [QuatW-1:0]   quat_t;
	typedef logic signed [ScaleW-1:0]  scale_t;
	typedef logic signed [OutW-1:0]    out_t;
	typedef logic signed [ProdW-1:0]   prod_t;
	typedef logic signed [RotW-1:0]    rot_t;
	typedef logic signed [PartLoW-1:0] part_lo_t;
	typedef logic signed [PartHiW-1:0] part_hi_t;
	typedef logic signed [FullW-1:0]   full_t;
	typedef logic signed [RoundW-1:0]  round_t;

	// 1.0 in Q.28
	localparam rot_t RotOne = {{(RotW-FracRot-1){1'b0}}, 1'b1, {FracRot{1'b0}}};

	localparam full_t HalfPos = {{(FullW-FracRot){1'b0}}, 1'b1, {(FracRot-1){1'b0}}};
	localparam full_t HalfNeg = {{(FullW-FracRot){1'b0}}, 1'b0, {(FracRot-1){1'b1}}};

	localparam round_t SatHi = {{(RoundW-OutW+1){1'b0}}, {(OutW-1){1'b1}}};
	localparam round_t SatLo = {{(RoundW-OutW+1){1'b1}}, {(OutW-1){1'b0}}};

	// Round Q.44 to Q16.16, ties away from zero, then clamp to 32 bits.
	// A negative value takes half minus one so the arithmetic shift matches
	// rounding of the magnitude.
	function automatic out_t round_sat(input full_t p);
		full_t  sum;
		round_t q;
		sum = p + (p[FullW-1] ? HalfNeg : HalfPos);
		q   = sum[FullW-1:FracRot];
		if (q > SatHi)
			return SatHi[OutW-1:0];
		else if (q < SatLo)
			return SatLo[OutW-1:0];
		else
			return q[OutW-1:0];
	endfunction

endpackage

>>> rtl/trs_to_affine_matrix.sv
// ----------------------------------------------------------------------------
// trs_to_affine_matrix
// Top three rows of T*R*S from translation, Q1.14 quaternion and scale.
// ----------------------------------------------------------------------------
//
//   channel | handshake            | payload
//   --------+----------------------+-------------------------------------------
//   in      | in_valid / in_stall  | trans_x..z, quat_x..w, scale_x..z
//   out     | out_valid/ out_stall | m00..m23 (Q16.16, rotation part saturated)
//
// Five register stages: quaternion products, rotation entries, split partial
// products with the scale, full product, round and saturate. One beat enters
// per cycle while in_stall is low; the 16x16 and 18x32 multipliers set the
// stage depth. Reset clears the stage valid bits only. A stall on the out
// side fills bubbles first and backs up into in_stall only when all five
// stages hold a beat.
//
`include "trs_to_affine_matrix_macros.svh"

module trs_to_affine_matrix (
	input  logic                  clk,
	input  logic                  arst_n,

	input  logic                  in_valid,
	output logic                  in_stall,
	input  tta_pkg::trans_t       trans_x,
	input  tta_pkg::trans_t       trans_y,
	input  tta_pkg::trans_t       trans_z,
	input  tta_pkg::quat_t        quat_x,
	input  tta_pkg::quat_t        quat_y,
	input  tta_pkg::quat_t        quat_z,
	input  tta_pkg::quat_t        quat_w,
	input  tta_pkg::scale_t       scale_x,
	input  tta_pkg::scale_t       scale_y,
	input  tta_pkg::scale_t       scale_z,

	output logic                  out_valid,
	input  logic                  out_stall,
	output tta_pkg::out_t         m00,
	output tta_pkg::out_t         m01,
	output tta_pkg::out_t         m02,
	output tta_pkg::out_t         m03,
	output tta_pkg::out_t         m10,
	output tta_pkg::out_t         m11,
	output tta_pkg::out_t         m12,
	output tta_pkg::out_t         m13,
	output tta_pkg::out_t         m20,
	output tta_pkg::out_t         m21,
	output tta_pkg::out_t         m22,
	output tta_pkg::out_t         m23
);

	localparam int Dim = 3;

	// stage valids and advance enables
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic en_s1, en_s2, en_s3, en_s4, en_s5;

	tta_pkg::trans_t   trans_in [Dim];
	tta_pkg::scale_t   scale_in [Dim];

	// stage 1: quaternion products
	tta_pkg::prod_t    xx_s1, yy_s1, zz_s1, xy_s1, xz_s1, yz_s1, xw_s1, yw_s1, zw_s1;
	tta_pkg::trans_t   trans_s1 [Dim];
	tta_pkg::scale_t   scale_s1 [Dim];

	// stage 2: rotation entries, row-major
	tta_pkg::rot_t     rot_s2   [Dim*Dim];
	tta_pkg::trans_t   trans_s2 [Dim];
	tta_pkg::scale_t   scale_s2 [Dim];

	// stage 3: partial products
	tta_pkg::part_lo_t plo_s3   [Dim*Dim];
	tta_pkg::part_hi_t phi_s3   [Dim*Dim];
	tta_pkg::trans_t   trans_s3 [Dim];

	// stage 4: exact products
	tta_pkg::full_t    full_s4  [Dim*Dim];
	tta_pkg::trans_t   trans_s4 [Dim];

	// stage 5: output register
	tta_pkg::out_t     m_s5     [Dim*Dim];
	tta_pkg::trans_t   trans_s5 [Dim];

	assign trans_in[0] = trans_x;
	assign trans_in[1] = trans_y;
	assign trans_in[2] = trans_z;
	assign scale_in[0] = scale_x;
	assign scale_in[1] = scale_y;
	assign scale_in[2] = scale_z;

	// a stage advances when empty or when the next one advances
	assign en_s5 = !v_s5 || !out_stall;
	assign en_s4 = !v_s4 || en_s5;
	assign en_s3 = !v_s3 || en_s4;
	assign en_s2 = !v_s2 || en_s3;
	assign en_s1 = !v_s1 || en_s2;

	assign in_stall  = !en_s1;
	assign out_valid = v_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= in_valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
			if (en_s5) v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && in_valid) begin
			xx_s1 <= quat_x * quat_x;
			yy_s1 <= quat_y * quat_y;
			zz_s1 <= quat_z * quat_z;
			xy_s1 <= quat_x * quat_y;
			xz_s1 <= quat_x * quat_z;
			yz_s1 <= quat_y * quat_z;
			xw_s1 <= quat_x * quat_w;
			yw_s1 <= quat_y * quat_w;
			zw_s1 <= quat_z * quat_w;
			trans_s1 <= trans_in;
			scale_s1 <= scale_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2 && v_s1) begin
			rot_s2[0] <= tta_pkg::RotOne -
				((tta_pkg::rot_t'(yy_s1) + tta_pkg::rot_t'(zz_s1)) <<< 1);
			rot_s2[1] <= (tta_pkg::rot_t'(xy_s1) - tta_pkg::rot_t'(zw_s1)) <<< 1;
			rot_s2[2] <= (tta_pkg::rot_t'(xz_s1) + tta_pkg::rot_t'(yw_s1)) <<< 1;
			rot_s2[3] <= (tta_pkg::rot_t'(xy_s1) + tta_pkg::rot_t'(zw_s1)) <<< 1;
			rot_s2[4] <= tta_pkg::RotOne -
				((tta_pkg::rot_t'(xx_s1) + tta_pkg::rot_t'(zz_s1)) <<< 1);
			rot_s2[5] <= (tta_pkg::rot_t'(yz_s1) - tta_pkg::rot_t'(xw_s1)) <<< 1;
			rot_s2[6] <= (tta_pkg::rot_t'(xz_s1) - tta_pkg::rot_t'(yw_s1)) <<< 1;
			rot_s2[7] <= (tta_pkg::rot_t'(yz_s1) + tta_pkg::rot_t'(xw_s1)) <<< 1;
			rot_s2[8] <= tta_pkg::RotOne -
				((tta_pkg::rot_t'(xx_s1) + tta_pkg::rot_t'(yy_s1)) <<< 1);
			trans_s2 <= trans_s1;
			scale_s2 <= scale_s1;
		end
	end

	// split each entry into a signed high and an unsigned low slice
	always_ff @(posedge clk) begin
		if (en_s3 && v_s2) begin
			for (int r = 0; r < Dim; r++) begin
				for (int c = 0; c < Dim; c++) begin
					plo_s3[r*Dim+c] <=
						$signed({1'b0, rot_s2[r*Dim+c][tta_pkg::LoW-1:0]}) * scale_s2[c];
					phi_s3[r*Dim+c] <=
						$signed(rot_s2[r*Dim+c][tta_pkg::RotW-1:tta_pkg::LoW]) * scale_s2[c];
				end
			end
			trans_s3 <= trans_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s4 && v_s3) begin
			for (int k = 0; k < Dim*Dim; k++) begin
				full_s4[k] <= (tta_pkg::full_t'(phi_s3[k]) <<< tta_pkg::LoW) +
					tta_pkg::full_t'(plo_s3[k]);
			end
			trans_s4 <= trans_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s5 && v_s4) begin
			for (int k = 0; k < Dim*Dim; k++) begin
				m_s5[k] <= tta_pkg::round_sat(full_s4[k]);
			end
			trans_s5 <= trans_s4;
		end
	end

	assign m00 = m_s5[0];
	assign m01 = m_s5[1];
	assign m02 = m_s5[2];
	assign m03 = trans_s5[0];
	assign m10 = m_s5[3];
	assign m11 = m_s5[4];
	assign m12 = m_s5[5];
	assign m13 = trans_s5[1];
	assign m20 = m_s5[6];
	assign m21 = m_s5[7];
	assign m22 = m_s5[8];
	assign m23 = trans_s5[2];

	`TTA_ASSERT_NOW(a_stall_only_when_full, in_stall,
		v_s1 && v_s2 && v_s3 && v_s4 && v_s5 && out_stall,
		"input stalled while the pipeline has a bubble")

	`TTA_ASSERT_NEXT(a_stream_no_gap, out_valid && !out_stall && v_s4, out_valid,
		"beat in stage four lost on output advance")

	`TTA_ASSERT_NEXT(a_drain_empty, out_valid && !out_stall && !v_s4, !out_valid,
		"output beat repeated after delivery")

endmodule
